/* design/lps_pkg.sv */
// Shared constants, types and the message ROM of the LED panel scroller.
package lps_pkg;

  localparam int unsigned PanelColumnsDef   = 32;
  localparam int unsigned MessageColumnsDef = 64;
  localparam int unsigned RomDepth          = 64;
  localparam int unsigned DelayW            = 13;
  localparam int unsigned DelayBase         = 4525;
  localparam int unsigned SpeedW            = 8;
  localparam int unsigned ColBitsW          = 8;
  localparam int unsigned ColIndexW         = 5;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_HORIZ = 2'd1,
    MODE_VERT  = 2'd2
  } mode_e;

  // controller -> datapath
  typedef struct packed {
    logic tick;  // accept an item and update state
    logic emit;  // load the next column into the output register
  } lps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic delay_zero;  // no delay running: an accepted item redraws
    logic col_zero;    // column counter is at the last column
    logic slot_free;   // output register can take a column this cycle
  } lps_status_t;

  function automatic logic [7:0] rom_byte(input logic [7:0] idx);
    logic [7:0] b;
    case (idx)
      8'd0:  b = 8'h00;  8'd1:  b = 8'h42;  8'd2:  b = 8'h24;  8'd3:  b = 8'h18;
      8'd4:  b = 8'h18;  8'd5:  b = 8'h24;  8'd6:  b = 8'h42;  8'd7:  b = 8'h00;
      8'd8:  b = 8'h00;  8'd9:  b = 8'h30;  8'd10: b = 8'h48;  8'd11: b = 8'h48;
      8'd12: b = 8'h48;  8'd13: b = 8'h48;  8'd14: b = 8'h7E;  8'd15: b = 8'h00;
      8'd16: b = 8'h00;  8'd17: b = 8'h3C;  8'd18: b = 8'h40;  8'd19: b = 8'h40;
      8'd20: b = 8'h40;  8'd21: b = 8'h40;  8'd22: b = 8'h3C;  8'd23: b = 8'h00;
      8'd24: b = 8'h00;  8'd25: b = 8'h30;  8'd26: b = 8'h48;  8'd27: b = 8'h48;
      8'd28: b = 8'h48;  8'd29: b = 8'h48;  8'd30: b = 8'h7E;  8'd31: b = 8'h00;
      8'd32: b = 8'h00;  8'd33: b = 8'h00;  8'd34: b = 8'h3C;  8'd35: b = 8'h4A;
      8'd36: b = 8'h4A;  8'd37: b = 8'h4A;  8'd38: b = 8'h2C;  8'd39: b = 8'h00;
      8'd40: b = 8'h00;  8'd41: b = 8'h00;  8'd42: b = 8'h7E;  8'd43: b = 8'h18;
      8'd44: b = 8'h24;  8'd45: b = 8'h42;  8'd46: b = 8'h00;  8'd47: b = 8'h00;
      8'd48: b = 8'h00;  8'd49: b = 8'h00;  8'd50: b = 8'h3C;  8'd51: b = 8'h42;
      8'd52: b = 8'h42;  8'd53: b = 8'h3C;  8'd54: b = 8'h00;  8'd55: b = 8'h00;
      8'd56: b = 8'h00;  8'd57: b = 8'h1E;  8'd58: b = 8'h10;  8'd59: b = 8'h10;
      8'd60: b = 8'h78;  8'd61: b = 8'h10;  8'd62: b = 8'h00;  8'd63: b = 8'h00;
      default: b = 8'h00;  // past the end of the message pattern
    endcase
    return b;
  endfunction

endpackage

/* design/lps_ctrl.sv */
// Controller state machine: item acceptance and column emit sequencing.
module lps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lps_pkg::lps_status_t status_i,
  output lps_pkg::lps_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   stall_q;

  always_comb begin
    cmd_o.tick = in_valid_i && (state_q == ST_IDLE);
    cmd_o.emit = (state_q == ST_EMIT) && status_i.slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && status_i.delay_zero) begin
            state_q <= ST_EMIT;
            stall_q <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (cmd_o.emit && status_i.col_zero) begin
            state_q <= ST_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall_o = stall_q;

endmodule

/* design/lps_datapath.sv */
// Datapath: mode, offsets, delay counter, column walk and output register.
module lps_datapath #(
  parameter int unsigned PANEL_COLUMNS   = lps_pkg::PanelColumnsDef,
  parameter int unsigned MESSAGE_COLUMNS = lps_pkg::MessageColumnsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lps_pkg::SpeedW-1:0]      cfg_wdata_i,
  input  logic                            init_button_i,
  input  logic                            horiz_button_i,
  input  logic                            vert_button_i,
  input  lps_pkg::lps_cmd_t               cmd_i,
  output lps_pkg::lps_status_t            status_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lps_pkg::ColIndexW-1:0]   column_index_o,
  output logic [lps_pkg::ColBitsW-1:0]    column_bits_o,
  output logic                            last_column_o
);

  localparam int unsigned CW = (PANEL_COLUMNS > 1) ? $clog2(PANEL_COLUMNS) : 1;
  localparam int unsigned IW = (MESSAGE_COLUMNS > 1) ? $clog2(MESSAGE_COLUMNS) : 1;
  localparam int unsigned DW = lps_pkg::DelayW;
  localparam int unsigned OW = lps_pkg::ColIndexW;
  // message index of the first (highest) panel column with no offset
  localparam int unsigned FirstIdx = (PANEL_COLUMNS - 1) % MESSAGE_COLUMNS;

  lps_pkg::mode_e          mode_q, mode_d;
  logic [IW-1:0]           h_q, h_d;
  logic [2:0]              v_q, v_d;
  logic [DW-1:0]           delay_q, delay_load;
  logic [lps_pkg::SpeedW-1:0] speed_q;
  logic [CW-1:0]           col_q;
  logic [IW-1:0]           idx_q, idx_start, idx_dec;
  logic [IW:0]             h_inc;
  logic [7:0]              rom_b;
  logic [15:0]             rot;
  logic                    out_valid_q;
  logic [lps_pkg::ColIndexW-1:0] col_out_q;
  logic [lps_pkg::ColBitsW-1:0]  bits_out_q;
  logic                    last_out_q;

  always_comb begin
    if (init_button_i)       mode_d = lps_pkg::MODE_INIT;
    else if (horiz_button_i) mode_d = lps_pkg::MODE_HORIZ;
    else if (vert_button_i)  mode_d = lps_pkg::MODE_VERT;
    else                     mode_d = mode_q;
  end

  // offsets after a redraw tick under the new mode
  always_comb begin
    h_inc = {1'b0, h_q} + (IW + 1)'(1);
    h_d   = h_q;
    v_d   = v_q;
    case (mode_d)
      lps_pkg::MODE_INIT: begin
        h_d = '0;
        v_d = '0;
      end
      lps_pkg::MODE_HORIZ: begin
        h_d = (h_inc == (IW + 1)'(MESSAGE_COLUMNS)) ? '0 : h_inc[IW-1:0];
      end
      lps_pkg::MODE_VERT: begin
        v_d = v_q + 3'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if ({1'b0, h_d} <= (IW + 1)'(FirstIdx)) begin
      idx_start = IW'((IW + 1)'(FirstIdx) - {1'b0, h_d});
    end else begin
      idx_start = IW'((IW + 1)'(FirstIdx) + (IW + 1)'(MESSAGE_COLUMNS) - {1'b0, h_d});
    end
    idx_dec = (idx_q == '0) ? IW'(MESSAGE_COLUMNS - 1) : idx_q - IW'(1);
  end

  // 4525 - 15 * speed = 4525 - 16 * speed + speed
  assign delay_load = DW'(lps_pkg::DelayBase) - (DW'(speed_q) << 4) + DW'(speed_q);

  assign rom_b = lps_pkg::rom_byte(8'(idx_q));
  assign rot   = {rom_b, rom_b} >> v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lps_pkg::MODE_INIT;
      h_q     <= '0;
      v_q     <= '0;
      delay_q <= '0;
      speed_q <= '0;
    end else begin
      if (cfg_we_i) speed_q <= cfg_wdata_i;
      if (cmd_i.tick) begin
        mode_q <= mode_d;
        if (delay_q != '0) begin
          delay_q <= delay_q - DW'(1);
        end else begin
          h_q <= h_d;
          v_q <= v_d;
          if (mode_d != lps_pkg::MODE_INIT) delay_q <= delay_load;
        end
      end
    end
  end

  // column walk, loaded at the start of a redraw
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick && (delay_q == '0)) begin
      col_q <= CW'(PANEL_COLUMNS - 1);
      idx_q <= idx_start;
    end else if (cmd_i.emit) begin
      col_q <= col_q - CW'(1);
      idx_q <= idx_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      col_out_q  <= OW'(col_q);
      bits_out_q <= rot[7:0];
      last_out_q <= (col_q == '0);
    end
  end

  always_comb begin
    status_o.delay_zero = (delay_q == '0);
    status_o.col_zero   = (col_q == '0);
    status_o.slot_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o    = out_valid_q;
  assign column_index_o = col_out_q;
  assign column_bits_o  = bits_out_q;
  assign last_column_o  = last_out_q;

endmodule

/* design/led_panel_scroller_top.sv */
// Top level of the LED panel scroller.
// Usage: each input item is one tick carrying three button levels
// (init, horizontal, vertical; init has priority). The buttons pick the
// mode on every accepted item. While a scroll delay is counting, an item
// only decrements it and gives no output, and the input is not stalled.
// When no delay runs, an item triggers a redraw: PANEL_COLUMNS result
// items, column PANEL_COLUMNS-1 down to 0, last_column set on column 0.
// The input channel is stalled from the cycle after such an item until
// its last column is in the output register. The item loads the column
// counter and message index; the first column enters the output register
// once it is free, and with no output stall the columns then come one per
// cycle as the column counter walks the message ROM.
// The output register holds a column while out_stall_i is high; the
// column walk pauses with it, nothing is dropped. After the last column
// is loaded a new item is taken even if that column still waits.
// The user must write rotation_speed through cfg_we_i/cfg_wdata_i only while
// idle; the block does not check this. A scroll loads 4525 - 15 * speed delay
// ticks. Reset clears mode (init), both offsets, the delay and the speed; the
// first accepted item after reset redraws the panel.
module led_panel_scroller_top #(
  parameter int unsigned PANEL_COLUMNS   = lps_pkg::PanelColumnsDef,
  parameter int unsigned MESSAGE_COLUMNS = lps_pkg::MessageColumnsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lps_pkg::SpeedW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          init_button_i,
  input  logic                          horiz_button_i,
  input  logic                          vert_button_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lps_pkg::ColIndexW-1:0] column_index_o,
  output logic [lps_pkg::ColBitsW-1:0]  column_bits_o,
  output logic                          last_column_o
);

  lps_pkg::lps_cmd_t    cmd;
  lps_pkg::lps_status_t status;

  lps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lps_datapath #(
    .PANEL_COLUMNS   (PANEL_COLUMNS),
    .MESSAGE_COLUMNS (MESSAGE_COLUMNS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .init_button_i  (init_button_i),
    .horiz_button_i (horiz_button_i),
    .vert_button_i  (vert_button_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .column_index_o (column_index_o),
    .column_bits_o  (column_bits_o),
    .last_column_o  (last_column_o)
  );

  // an item taken while a delay counts never starts a redraw
  a_delay_tick_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !status.delay_zero |=> !in_stall_o)
    else $error("delay tick stalled the input");

  // an item taken with no delay running starts a redraw
  a_redraw_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && status.delay_zero |=> in_stall_o)
    else $error("redraw item did not stall the input");

  // columns other than the last are only delivered mid-redraw
  a_mid_redraw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_column_o |-> in_stall_o)
    else $error("column delivered outside a redraw");

endmodule

/* tb/led_panel_scroller_top_tb.sv */
// Testbench for the LED panel scroller: directed and random button ticks, every column checked.
module led_panel_scroller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ColIndexW         = lps_pkg::ColIndexW;
  localparam int unsigned ColBitsW          = lps_pkg::ColBitsW;
  localparam int unsigned SpeedW            = lps_pkg::SpeedW;
  localparam int unsigned DelayW            = lps_pkg::DelayW;
  localparam int unsigned DelayBase         = lps_pkg::DelayBase;
  localparam int unsigned RomDepth          = lps_pkg::RomDepth;
  localparam int unsigned PanelColumnsDef   = lps_pkg::PanelColumnsDef;
  localparam int unsigned MessageColumnsDef = lps_pkg::MessageColumnsDef;

  localparam int unsigned SpeedStep   = 15;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned CycleLimit  = 4_000_000;

  typedef struct packed {
    logic [ColIndexW-1:0] index;
    logic [ColBitsW-1:0]  col_bits;
    logic                 last;
  } column_t;

  typedef enum int {RUN_HORIZ, RUN_VERT, RUN_INIT, RUN_NOISE} run_kind_e;

  // Tracks scroller state and the columns each accepted tick should produce.
  class column_scoreboard;
    bit [7:0]        msg_rom [RomDepth];
    lps_pkg::mode_e  mode;
    bit [5:0]        h_offset;
    bit [2:0]        v_offset;
    bit [DelayW-1:0] delay_left;
    bit [SpeedW-1:0] speed;
    column_t         pending[$];
    int unsigned     errors, ticks, redraws, h_scrolls, v_scrolls, h_wraps, columns_seen;

    function new();
      msg_rom = '{
        8'h00, 8'h42, 8'h24, 8'h18, 8'h18, 8'h24, 8'h42, 8'h00,
        8'h00, 8'h30, 8'h48, 8'h48, 8'h48, 8'h48, 8'h7E, 8'h00,
        8'h00, 8'h3C, 8'h40, 8'h40, 8'h40, 8'h40, 8'h3C, 8'h00,
        8'h00, 8'h30, 8'h48, 8'h48, 8'h48, 8'h48, 8'h7E, 8'h00,
        8'h00, 8'h00, 8'h3C, 8'h4A, 8'h4A, 8'h4A, 8'h2C, 8'h00,
        8'h00, 8'h00, 8'h7E, 8'h18, 8'h24, 8'h42, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h3C, 8'h42, 8'h42, 8'h3C, 8'h00, 8'h00,
        8'h00, 8'h1E, 8'h10, 8'h10, 8'h78, 8'h10, 8'h00, 8'h00
      };
      mode       = lps_pkg::MODE_INIT;
      h_offset   = '0;
      v_offset   = '0;
      delay_left = '0;
      speed      = '0;
    endfunction

    function void note_item(bit b_init, bit b_horiz, bit b_vert);
      int unsigned idx;
      bit [7:0]    rom_val;
      column_t     col;
      ticks++;
      if (b_init) mode = lps_pkg::MODE_INIT;
      else if (b_horiz) mode = lps_pkg::MODE_HORIZ;
      else if (b_vert) mode = lps_pkg::MODE_VERT;
      // buttons still steer the mode while the delay counts down
      if (delay_left != 0) begin
        delay_left--;
        return;
      end
      case (mode)
        lps_pkg::MODE_INIT: begin
          h_offset = '0;
          v_offset = '0;
        end
        lps_pkg::MODE_HORIZ: begin
          h_offset = 6'((int'(h_offset) + 1) % MessageColumnsDef);
          if (h_offset == 0) h_wraps++;
          delay_left = DelayW'(DelayBase - SpeedStep * speed);
          h_scrolls++;
        end
        lps_pkg::MODE_VERT: begin
          v_offset = v_offset + 3'd1;
          delay_left = DelayW'(DelayBase - SpeedStep * speed);
          v_scrolls++;
        end
        default: return;
      endcase
      redraws++;
      for (int c = PanelColumnsDef - 1; c >= 0; c--) begin
        idx          = (c + MessageColumnsDef - h_offset) % MessageColumnsDef;
        rom_val      = (idx < RomDepth) ? msg_rom[idx] : 8'h00;
        col.index    = ColIndexW'(c);
        col.col_bits = 8'({rom_val, rom_val} >> v_offset);  // rotate right
        col.last     = (c == 0);
        pending.push_back(col);
      end
    endfunction

    function void check_column(logic [ColIndexW-1:0] index, logic [ColBitsW-1:0] col_bits,
                               logic last);
      column_t exp_col;
      if (pending.size() == 0) begin
        $error("column %0d arrived with no column expected", index);
        errors++;
        return;
      end
      exp_col = pending.pop_front();
      columns_seen++;
      if (index !== exp_col.index) begin
        $error("column_index: expected %0d, got %0d", exp_col.index, index);
        errors++;
      end
      if (col_bits !== exp_col.col_bits) begin
        $error("column_bits: expected 0x%02h, got 0x%02h", exp_col.col_bits, col_bits);
        errors++;
      end
      if (last !== exp_col.last) begin
        $error("last_column: expected %0b, got %0b", exp_col.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [SpeedW-1:0]    cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 init_button_i;
  logic                 horiz_button_i;
  logic                 vert_button_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [ColIndexW-1:0] column_index_o;
  logic [ColBitsW-1:0]  column_bits_o;
  logic                 last_column_o;

  column_scoreboard sb;
  int unsigned      src_idle_pct;
  int unsigned      snk_idle_pct;
  int unsigned      cycle_count;

  led_panel_scroller_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .init_button_i  (init_button_i),
    .horiz_button_i (horiz_button_i),
    .vert_button_i  (vert_button_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .column_index_o (column_index_o),
    .column_bits_o  (column_bits_o),
    .last_column_o  (last_column_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d columns still due", cycle_count,
               sb.pending.size());
      $display("led_panel_scroller_top test failed");
      $finish;
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sb.check_column(column_index_o, column_bits_o, last_column_o);
  end

  task automatic send_tick(input bit b_init, input bit b_horiz, input bit b_vert);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    init_button_i  <= b_init;
    horiz_button_i <= b_horiz;
    vert_button_i  <= b_vert;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_item(b_init, b_horiz, b_vert);
  endtask

  // run the scroll delay down to a given remainder with filler ticks
  task automatic drain_delay(input int unsigned keep, input bit noisy);
    bit [2:0] btn;
    while (sb.delay_left > keep) begin
      btn = (noisy && $urandom_range(15) == 0) ? 3'($urandom) : 3'b000;
      send_tick(btn[2], btn[1], btn[0]);
    end
  endtask

  task automatic start_phase(input bit [SpeedW-1:0] speed, input int unsigned src_pct,
                             input int unsigned snk_pct);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= speed;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    sb.speed     = speed;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  task automatic run_phase(input int unsigned budget, input bit long_horiz);
    int unsigned sent;
    int unsigned run_len;
    int unsigned pick;
    int unsigned keep;
    run_kind_e   kind;
    bit          b_init, b_horiz, b_vert;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(19);
      if (long_horiz) begin
        // a run of horizontal ticks longer than the message, to try to wrap the column offset
        kind       = RUN_HORIZ;
        run_len    = MessageColumnsDef + 2;
        long_horiz = 1'b0;
      end else if (pick < 7) begin
        kind    = RUN_HORIZ;
        run_len = $urandom_range(20, 1);
      end else if (pick < 13) begin
        kind    = RUN_VERT;
        run_len = $urandom_range(12, 1);
      end else if (pick < 16) begin
        kind    = RUN_INIT;
        run_len = $urandom_range(4, 1);
      end else begin
        kind    = RUN_NOISE;
        run_len = $urandom_range(6, 1);
      end
      for (int k = 0; k < run_len && sent < budget; k++) begin
        if (kind == RUN_NOISE) keep = $urandom_range(5);
        else keep = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
        drain_delay(keep, kind == RUN_NOISE);
        case (kind)
          RUN_HORIZ: begin
            b_init  = 1'b0;
            b_horiz = (k == 0) ? 1'b1 : 1'($urandom);
            b_vert  = b_horiz ? 1'($urandom) : 1'b0;
          end
          RUN_VERT: begin
            b_init  = 1'b0;
            b_horiz = 1'b0;
            b_vert  = (k == 0) ? 1'b1 : 1'($urandom);
          end
          RUN_INIT: begin
            b_init  = (k == 0) ? 1'b1 : 1'($urandom);
            b_horiz = b_init ? 1'($urandom) : 1'b0;
            b_vert  = b_init ? 1'($urandom) : 1'b0;
          end
          default: begin
            b_init  = 1'($urandom);
            b_horiz = 1'($urandom);
            b_vert  = 1'($urandom);
          end
        endcase
        send_tick(b_init, b_horiz, b_vert);
        sent++;
      end
    end
  endtask

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    init_button_i  = 1'b0;
    horiz_button_i = 1'b0;
    vert_button_i  = 1'b0;
    out_stall_i    = 1'b0;
    src_idle_pct   = 0;
    snk_idle_pct   = 0;
    cycle_count    = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    start_phase(8'd255, 30, 68);
    send_tick(1'b0, 1'b0, 1'b0);  // mode is init out of reset: plain redraw
    send_tick(1'b1, 1'b1, 1'b1);  // init wins over both scroll buttons
    send_tick(1'b0, 1'b1, 1'b1);  // horizontal wins over vertical, loads delay
    send_tick(1'b0, 1'b0, 1'b1);  // switch to vertical while the delay runs
    drain_delay(0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);  // held vertical mode acts
    drain_delay(1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);  // last delay tick, mode goes to init
    send_tick(1'b0, 1'b0, 1'b0);  // init clears both offsets
    send_tick(1'b0, 1'b1, 1'b0);
    drain_delay(0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);
    // walk every row rotation and wrap back to zero
    for (int r = 0; r < 9; r++) begin
      drain_delay(0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b1);
    end
    drain_delay(0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);

    run_phase(170, 1'b1);
    start_phase(8'($urandom_range(254, 230)), 68, 30);
    run_phase(120, 1'b0);
    start_phase(8'd0, 0, 0);
    run_phase(12, 1'b0);
    start_phase(8'($urandom_range(255, 200)), 0, 0);
    run_phase(170, 1'b0);

    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("ran %0d ticks in %0d cycles: %0d redraws, %0d columns checked",
             sb.ticks, cycle_count, sb.redraws, sb.columns_seen);
    $display("%0d horizontal scrolls (%0d offset wraps), %0d vertical rotations",
             sb.h_scrolls, sb.h_wraps, sb.v_scrolls);
    if (sb.errors == 0) begin
      $display("led_panel_scroller_top test passed");
    end else begin
      $display("led_panel_scroller_top test failed");
    end
    $finish;
  end

endmodule
